// ----- rtl/swm_pkg.sv -----
package swm_pkg;

  // defaults for the top level parameters
  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // width of the window length register
  localparam int CFG_WIDTH = 7;

  // control broadcast to every cell of the candidate row
  typedef struct packed {
    logic start;   // request opens a new sequence, row is cleared
    logic insert;  // request accepted: pop smaller values, append sample
    logic full;    // every candidate survives: row shifts toward the front, front is dropped
    logic pop;     // front leaves the window, row shifts toward the front
  } cell_ctl_t;

endpackage

// ----- rtl/swm_cell.sv -----
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cell_ctl_t                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           keep_prev,
  input  logic signed [SAMPLE_WIDTH-1:0] nxt_val,
  input  logic                           nxt_vld,
  output logic signed [SAMPLE_WIDTH-1:0] val,
  output logic                           vld,
  output logic                           keep
);

  // candidate survives when it is not smaller than the new sample
  assign keep = !ctl.start && vld && (val >= sample);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.insert) begin
      if (ctl.full) begin
        vld <= nxt_vld;
      end else if (!keep) begin
        vld <= keep_prev;
      end
    end else if (ctl.pop) begin
      vld <= nxt_vld;
    end
  end

  // candidate value
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (ctl.full) begin
        val <= nxt_val;
      end else if (!keep && keep_prev) begin
        val <= sample;
      end
    end else if (ctl.pop) begin
      val <= nxt_val;
    end
  end

endmodule

// ----- rtl/swm_history.sv -----
module swm_history
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int AW          = $clog2(MAX_WINDOW)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [SAMPLE_WIDTH-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [SAMPLE_WIDTH-1:0] rd_data
);

  logic [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/sliding_window_max.sv -----
// Running maximum over the last window_len signed samples. A sample with the
// start flag in tuser opens a new sequence; once window_len samples of the
// sequence have arrived every sample yields one result, before that none.
// Candidates live in a row of compare cells with the front in cell 0: on
// acceptance every cell compares itself against the new sample in parallel,
// smaller ones drop out and the sample lands behind the survivors. Each
// sample passes an accept phase, which updates the cell row and issues the
// read of the leaving sample from the history memory, and a finish phase set
// by its registered read port, in which the front is reported and retired if
// it equals that sample. The finish phase lasts while the output register
// holds a result not yet taken, and no new sample is accepted until it ends.
// window_len is taken as 1 when written as zero and as MAX_WINDOW above
// that; it must be written only while no sample is in flight (not enforced by the block).
module sliding_window_max
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int DW          = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,     // window_len
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DW-1:0]        s_axis_tdata,  // sample
  input  logic                 s_axis_tuser,  // start_req
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DW-1:0]        m_axis_tdata   // window_max
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int KW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (KW > CFG_WIDTH) ? KW + 1 : CFG_WIDTH + 1;

  localparam logic PH_IDLE   = 1'b0;
  localparam logic PH_FINISH = 1'b1;

  logic                           phase;
  logic [CFG_WIDTH-1:0]           window_len;
  logic [KW-1:0]                  k_len;
  logic [KW-1:0]                  fill;
  logic [KW-1:0]                  fill_base;
  logic [KW-1:0]                  fill_next;
  logic [AW-1:0]                  hist_ptr;
  logic [AW-1:0]                  cur;
  logic [AW-1:0]                  km1;
  logic [AW-1:0]                  rd_addr;
  logic [SAMPLE_WIDTH-1:0]        hist_rd;
  logic signed [SAMPLE_WIDTH-1:0] smp_in;
  logic signed [SAMPLE_WIDTH-1:0] smp_q;
  logic signed [SAMPLE_WIDTH-1:0] oldest;
  logic [SAMPLE_WIDTH-1:0]        out_val;
  logic                           accept;
  logic                           finish;
  logic                           result;
  logic                           front_retire;
  cell_ctl_t                      ctl;

  logic signed [SAMPLE_WIDTH-1:0] vals [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]          vld;
  logic [MAX_WINDOW-1:0]          keep;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= CFG_WIDTH'(1);
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  // effective window length
  always_comb begin
    if (window_len == '0) begin
      k_len = KW'(1);
    end else if (CW'(window_len) > CW'(MAX_WINDOW)) begin
      k_len = KW'(MAX_WINDOW);
    end else begin
      k_len = KW'(window_len);
    end
  end

  assign smp_in        = signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]);
  assign s_axis_tready = (phase == PH_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign finish        = (phase == PH_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // history position of this sample and of the one leaving the window
  assign cur = s_axis_tuser ? '0 : hist_ptr;
  assign km1 = AW'(k_len - 1'b1);
  always_comb begin
    if (cur >= km1) begin
      rd_addr = cur - km1;
    end else begin
      rd_addr = AW'((AW + 1)'(cur) + (AW + 1)'(MAX_WINDOW) - (AW + 1)'(km1));
    end
  end

  // fill count, saturating at the window length
  assign fill_base = s_axis_tuser ? '0 : fill;
  assign fill_next = (fill_base < k_len) ? fill_base + 1'b1 : k_len;

  // sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      hist_ptr <= '0;
      fill     <= '0;
    end else if (accept) begin
      phase    <= PH_FINISH;
      hist_ptr <= (cur == AW'(MAX_WINDOW - 1)) ? '0 : cur + 1'b1;
      fill     <= fill_next;
    end else if (finish) begin
      phase    <= PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_q <= smp_in;
    end
  end

  swm_history #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (cur),
    .wr_data (smp_in),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (hist_rd)
  );

  // with a window of one the leaving sample is the one just taken
  assign oldest       = (k_len == KW'(1)) ? smp_q : signed'(hist_rd);
  assign result       = (fill == k_len);
  assign front_retire = finish && result && (vals[0] == oldest);

  // cell row control
  assign ctl.start  = s_axis_tuser;
  assign ctl.insert = accept;
  assign ctl.full   = keep[MAX_WINDOW-1];
  assign ctl.pop    = front_retire;

  // candidate row, front in cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                           kp;
    logic signed [SAMPLE_WIDTH-1:0] nv;
    logic                           nvld;

    if (i == 0) begin : g_first
      assign kp = 1'b1;
    end else begin : g_rest
      assign kp = keep[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign nv   = smp_in;
      assign nvld = ctl.insert;
    end else begin : g_mid
      assign nv   = vals[i+1];
      assign nvld = vld[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sample    (smp_in),
      .keep_prev (kp),
      .nxt_val   (nv),
      .nxt_vld   (nvld),
      .val       (vals[i]),
      .vld       (vld[i]),
      .keep      (keep[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish && result) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && result) begin
      out_val <= unsigned'(vals[0]);
    end
  end

  assign m_axis_tdata = DW'(out_val);

  // occupied cells always form a run starting at the front
  a_vld_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld >> 1) & ~vld) == '0)
    else $error("candidate row has a gap");

  // after a sample is taken in the front cell holds a candidate
  a_front_vld: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FINISH |-> vld[0])
    else $error("candidate row empty after insert");

  // a new result appears only out of the finishing cycle
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(phase) == PH_FINISH)
    else $error("result raised outside finishing cycle");

  // history pointer stays inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    accept |=> hist_ptr <= AW'(MAX_WINDOW - 1))
    else $error("history pointer out of range");

endmodule

// ----- test/sliding_window_max_test.sv -----
`timescale 1ns / 100ps

module sliding_window_max_test;
  import swm_pkg::*;

  localparam int MAX_W = MAX_WINDOW_DEF;
  localparam int DW    = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;

  typedef struct {
    logic signed [DW-1:0] value;
    bit                   first;
  } sample_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DW-1:0]        s_axis_tdata = '0;  // sample
  logic                 s_axis_tuser = 1'b0;  // start_req
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DW-1:0]        m_axis_tdata;  // window_max

  sliding_window_max dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // stimulus and expectation stores
  sample_req_t          pending[$];
  sample_req_t          on_bus;
  logic signed [DW-1:0] max_due[$];
  int                   send_idle = 0;
  int                   recv_stall = 0;
  int                   fail_count = 0;

  // mirror of the block state
  logic signed [DW-1:0]  cand[MAX_W];
  logic signed [DW-1:0]  hist[MAX_W];
  int                    q_head = 0;
  int                    q_count = 0;
  int                    h_ptr = 0;
  int                    fill = 0;
  logic [CFG_WIDTH-1:0]  win_len = CFG_WIDTH'(1);

  initial begin
    forever #1 clk = ~clk;
  end

  // update the candidate queue for one accepted sample, queue the maximum if due
  task automatic track_sample(input logic signed [DW-1:0] v, input bit first);
    int k;
    int cur;
    k = (win_len == 0) ? 1 : ((win_len > MAX_W) ? MAX_W : int'(win_len));
    if (first) begin
      q_head = 0;
      q_count = 0;
      fill = 0;
      h_ptr = 0;
    end
    // smaller values at the back can never be the maximum again
    while (q_count > 0) begin
      if (cand[(q_head + q_count - 1) % MAX_W] < v) q_count--;
      else break;
    end
    // no room left: oldest candidate is dropped
    if (q_count >= MAX_W) begin
      q_head = (q_head + 1) % MAX_W;
      q_count = MAX_W - 1;
    end
    cand[(q_head + q_count) % MAX_W] = v;
    q_count++;
    cur = h_ptr;
    hist[cur] = v;
    h_ptr = (cur + 1) % MAX_W;
    if (fill < k) fill++;
    else fill = k;
    if (fill == k) begin
      max_due.insert(max_due.size(), cand[q_head]);
      // retire the front once its sample leaves the window
      if (cand[q_head] == hist[(cur + MAX_W - (k - 1)) % MAX_W]) begin
        q_head = (q_head + 1) % MAX_W;
        q_count--;
      end
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_sample(on_bus.value, on_bus.first);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          on_bus = pending[0];
          pending.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= on_bus.value;
          s_axis_tuser <= on_bus.first;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (max_due.size() == 0) begin
          $display("%0t: unexpected window_max, expected none, got %0d",
                   $time, $signed(m_axis_tdata));
          fail_count++;
        end else if (m_axis_tdata !== max_due[0]) begin
          $display("%0t: window_max mismatch, expected %0d, got %0d",
                   $time, max_due[0], $signed(m_axis_tdata));
          fail_count++;
          max_due.delete(0);
        end else begin
          max_due.delete(0);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic add_sample(input logic signed [DW-1:0] v, input bit first);
    sample_req_t r;
    r.value = v;
    r.first = first;
    pending.insert(pending.size(), r);
  endtask

  // block idle: all samples taken, all maxima seen, pipeline drained
  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || s_axis_tvalid || max_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(input int len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_WIDTH'(len);
    win_len = CFG_WIDTH'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random sequences: mostly a start followed by related samples
  task automatic add_sequences(input int n, input int k);
    int added;
    int len;
    int style;
    logic signed [DW-1:0] v;
    logic signed [DW-1:0] step;
    added = 0;
    while (added < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 4 * k) : $urandom_range(1, 3 * k);
      style = $urandom_range(3);
      v = $urandom;
      for (int i = 0; i < len && added < n; i++) begin
        step = $urandom_range(0, 5);
        case (style)
          0: v = $urandom;
          1: v = $signed($urandom_range(0, 7)) - 4;
          2: v = v - step;
          default: v = v + step;
        endcase
        // occasional extreme values
        if ($urandom_range(15) == 0) v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
        // broken sequences: missing start, or a stray start inside
        add_sample(v, (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0));
        added++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicates, restart before the window fills
    set_window(3);
    add_sample(32'sh7fffffff, 1);
    add_sample(32'sh80000000, 0);
    add_sample(0, 0);
    add_sample(-1, 0);
    add_sample(-1, 0);
    add_sample(5, 0);
    add_sample(5, 0);
    add_sample(5, 0);
    add_sample(5, 0);
    add_sample(1, 0);
    add_sample(7, 0);
    add_sample(10, 1);
    add_sample(20, 1);
    add_sample(30, 0);
    add_sample(25, 0);
    add_sample(32'sh80000000, 0);
    add_sample(32'sh80000000, 0);
    add_sample(32'sh80000000, 0);
    drain();
    // zero length acts as one
    set_window(0);
    add_sample(32'sh80000000, 1);
    add_sample(32'sh7fffffff, 0);
    add_sample(0, 0);
    add_sample(-1, 1);
    drain();

    // length changed within a sequence; shrinking lets the queue overflow
    send_idle = 27;
    recv_stall = 27;
    set_window(64);
    for (int i = 0; i < 40; i++) add_sample(1000 - i, i == 0);
    drain();
    set_window(2);
    for (int i = 40; i < 70; i++) add_sample(1000 - i, 0);
    drain();
    set_window(9);
    for (int i = 0; i < 20; i++) add_sample($signed($urandom_range(0, 7)) - 4, 0);
    drain();

    // random phases under varying flow control
    send_idle = 0;
    recv_stall = 0;
    set_window(1);
    add_sequences(100, 1);
    drain();
    send_idle = 68;
    set_window(5);
    add_sequences(140, 5);
    drain();
    send_idle = 0;
    recv_stall = 68;
    set_window(64);
    add_sequences(200, 64);
    drain();
    send_idle = 27;
    recv_stall = 27;
    set_window(127);
    add_sequences(160, 64);
    drain();
    send_idle = 0;
    recv_stall = 0;
    begin
      int k;
      k = $urandom_range(2, 20);
      set_window(k);
      add_sequences(120, k);
      drain();
      send_idle = 27;
      recv_stall = 27;
      k = $urandom_range(1, 12);
      set_window(k);
      add_sequences(120, k);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS sliding_window_max");
    end else begin
      $display("FAIL sliding_window_max");
    end
    $finish;
  end

  // run limit
  initial begin
    #1000000;
    $display("FAIL sliding_window_max");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_history.sv
rtl/sliding_window_max.sv
test/sliding_window_max_test.sv
